>>> src/rvx_pkg.sv
// Shared types and constants for the RV32IM execute unit.
// No dependencies; the files that use it refer to it by scoped names.
package rvx_pkg;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MD   = 7'h01;

    // APB register byte addresses
    localparam logic [2:0] REG_START_ADDRESS = 3'd0;

    // data memory byte request / response
    typedef struct packed {
        logic        valid;
        logic        we;
        logic [31:0] addr;
        logic [7:0]  wbyte;
    } t_mreq;

    typedef struct packed {
        logic       ready;
        logic       done;
        logic [7:0] rbyte;
    } t_mrsp;

    // multiply / divide request / response
    typedef struct packed {
        logic        start;
        logic [2:0]  f3;
        logic [31:0] a;
        logic [31:0] b;
    } t_mdreq;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_mdrsp;

endpackage

>>> src/rvx_if.sv
// Valid/ready channel interfaces for instruction input and result output.
// Standalone; no package dependency.
interface rvx_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    modport source (output valid, output instruction, input ready);
    modport sink (input valid, input instruction, output ready);
endinterface

interface rvx_result_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [4:0]  dest_index;
    logic [31:0] write_value;
    logic        branch_taken;
    logic [31:0] next_address;
    logic        illegal;
    modport source (output valid, output write_enable, output dest_index,
                    output write_value, output branch_taken, output next_address,
                    output illegal, input ready);
    modport sink (input valid, input write_enable, input dest_index,
                  input write_value, input branch_taken, input next_address,
                  input illegal, output ready);
endinterface

>>> src/rv32im_execute_unit.sv
// RV32IM execute unit top level: sequencer, decode, ALU, branch, LSU and the M-extension unit.
// Depends on rvx_pkg, rvx_if, rvx_regfile, rvx_dmem, rvx_muldiv.
//
// Usage: instructions arrive on i_instr (valid/ready), one result per
// instruction leaves on o_result (valid/ready). start_address is set over
// the APB port (byte address 0) and is taken as the PC by the first
// instruction after reset.
// Sequence per instruction: transfer in, register read (S_RREG), execute
// (S_EXEC), then S_DONE. MUL and DIV/REM wait in S_MD for the multiply /
// divide unit (32-step divider); loads and stores issue one byte request
// per byte through S_MEM and S_MEMW, and with a MEM_WORDS that is not a
// power of two the data memory adds reciprocal address reduction to each
// byte.
// One instruction is in flight at a time; the next can be taken in the same
// cycle that the previous result first shows valid on o_result.
// Reset: the data memory is zeroed by a sweep of MEM_WORDS cycles, during
// which i_instr.ready stays low; APB writes are taken throughout.
// Receiver stall: the result holds in the output register; a following
// instruction still executes and waits for that register to free up.
module rv32im_execute_unit #(
    parameter int MEM_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvx_instr_if.sink   i_instr,
    rvx_result_if.source o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [2:0] {
        S_IDLE, S_RREG, S_EXEC, S_MD, S_MEM, S_MEMW, S_DONE
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [31:0]     r_start;
    logic [31:0]     r_pc;
    logic            r_pc_loaded;
    logic [31:0]     r_ins;
    logic [31:0]     r_addr;
    logic [31:0]     r_sdata;
    logic            r_store;
    logic [1:0]      r_cnt;
    logic [1:0]      r_last;
    logic [31:0]     r_acc;
    logic            r_wr;
    logic [31:0]     r_val;
    logic            r_taken;
    logic [31:0]     r_next;
    logic            r_bad;
    logic            r_ovalid;
    logic            r_owe;
    logic [4:0]      r_ord;
    logic [31:0]     r_oval;
    logic            r_otaken;
    logic [31:0]     r_onext;
    logic            r_obad;

    logic [31:0]     w_a;
    logic [31:0]     w_b;
    logic [6:0]      w_opc;
    logic [2:0]      w_f3;
    logic [6:0]      w_f7;
    logic [4:0]      w_rd;
    logic [31:0]     w_imm_i;
    logic [31:0]     w_imm_s;
    logic [31:0]     w_imm_b;
    logic            w_cond;
    logic            w_take_out;
    logic            w_commit;
    logic [31:0]     w_ld;
    logic [31:0]     w_acc_n;
    rvx_pkg::t_mreq  w_mreq;
    rvx_pkg::t_mrsp  w_mrsp;
    rvx_pkg::t_mdreq w_mdreq;
    rvx_pkg::t_mdrsp w_mdrsp;

    function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                        input logic [31:0] a, input logic [31:0] b);
        logic [31:0] res;
        case (f3)
            3'd0: res = alt ? (a - b) : (a + b);
            3'd1: res = a << b[4:0];
            3'd2: res = {31'd0, $signed(a) < $signed(b)};
            3'd3: res = {31'd0, a < b};
            3'd4: res = a ^ b;
            3'd5: res = alt ? 32'($signed(a) >>> b[4:0]) : (a >> b[4:0]);
            3'd6: res = a | b;
            default: res = a & b;
        endcase
        return res;
    endfunction

    assign w_opc   = r_ins[6:0];
    assign w_rd    = r_ins[11:7];
    assign w_f3    = r_ins[14:12];
    assign w_f7    = r_ins[31:25];
    assign w_imm_i = {{20{r_ins[31]}}, r_ins[31:20]};
    assign w_imm_s = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
    assign w_imm_b = {{20{r_ins[31]}}, r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};

    rvx_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (r_state == S_RREG),
        .i_ra    (r_ins[19:15]),
        .i_rb    (r_ins[24:20]),
        .i_we    (w_commit && r_wr && (w_rd != 5'd0)),
        .i_wa    (w_rd),
        .i_wd    (r_val),
        .o_a     (w_a),
        .o_b     (w_b)
    );

    assign w_mreq.valid = (r_state == S_MEM);
    assign w_mreq.we    = r_store;
    assign w_mreq.addr  = r_addr + {30'd0, r_cnt};
    assign w_mreq.wbyte = 8'(r_sdata >> {r_cnt, 3'b000});

    rvx_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    assign w_mdreq.start = (r_state == S_EXEC) && (w_opc == rvx_pkg::OPC_OP)
                           && (w_f7 == rvx_pkg::F7_MD);
    assign w_mdreq.f3    = w_f3;
    assign w_mdreq.a     = w_a;
    assign w_mdreq.b     = w_b;

    rvx_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mdreq),
        .o_rsp   (w_mdrsp)
    );

    always_comb begin
        case (w_f3)
            3'd0:    w_cond = (w_a == w_b);
            3'd1:    w_cond = (w_a != w_b);
            3'd4:    w_cond = $signed(w_a) < $signed(w_b);
            3'd5:    w_cond = !($signed(w_a) < $signed(w_b));
            3'd6:    w_cond = (w_a < w_b);
            default: w_cond = (w_a >= w_b);
        endcase
    end

    always_comb begin
        w_acc_n = r_acc;
        w_acc_n[r_cnt*8 +: 8] = w_mrsp.rbyte;
        case (w_f3)
            3'd0:    w_ld = {{24{w_acc_n[7]}}, w_acc_n[7:0]};
            3'd1:    w_ld = {{16{w_acc_n[15]}}, w_acc_n[15:0]};
            3'd4:    w_ld = {24'd0, w_acc_n[7:0]};
            3'd5:    w_ld = {16'd0, w_acc_n[15:0]};
            default: w_ld = w_acc_n;
        endcase
    end

    assign w_take_out = !r_ovalid || o_result.ready;
    assign w_commit   = (r_state == S_DONE) && w_take_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_instr.valid && w_mrsp.ready) n_state = S_RREG;
            S_RREG: n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_DONE;
                if (w_opc == rvx_pkg::OPC_LOAD && w_f3 != 3'd3 && w_f3 < 3'd6) begin
                    n_state = S_MEM;
                end else if (w_opc == rvx_pkg::OPC_STORE && w_f3 < 3'd3) begin
                    n_state = S_MEM;
                end else if (w_mdreq.start) begin
                    n_state = S_MD;
                end
            end
            S_MD:   if (w_mdrsp.done) n_state = S_DONE;
            S_MEM:  n_state = S_MEMW;
            S_MEMW: if (w_mrsp.done) n_state = (r_cnt == r_last) ? S_DONE : S_MEM;
            S_DONE: if (w_take_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 32'd0;
            r_pc_loaded <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr == rvx_pkg::REG_START_ADDRESS) begin
                r_start <= pwdata;
            end
            if (r_state == S_IDLE && n_state == S_RREG) begin
                r_ins <= i_instr.instruction;
                if (!r_pc_loaded) begin
                    r_pc        <= r_start;
                    r_pc_loaded <= 1'b1;
                end
            end
            if (r_state == S_EXEC) begin
                r_wr    <= 1'b0;
                r_val   <= 32'd0;
                r_taken <= 1'b0;
                r_next  <= r_pc + 32'd4;
                r_bad   <= 1'b0;
                r_cnt   <= 2'd0;
                r_acc   <= 32'd0;
                r_sdata <= w_b;
                r_store <= (w_opc == rvx_pkg::OPC_STORE);
                r_last  <= (w_f3[1:0] == 2'd0) ? 2'd0 : (w_f3[1:0] == 2'd1) ? 2'd1 : 2'd3;
                case (w_opc)
                    rvx_pkg::OPC_LOAD: begin
                        r_addr <= w_a + w_imm_i;
                        if (w_f3 == 3'd3 || w_f3 > 3'd5) begin
                            r_bad <= 1'b1;
                        end
                    end
                    rvx_pkg::OPC_STORE: begin
                        r_addr <= w_a + w_imm_s;
                        if (w_f3 > 3'd2) begin
                            r_bad <= 1'b1;
                        end
                    end
                    rvx_pkg::OPC_OPIMM: begin
                        if ((w_f3 == 3'd1 && w_f7 != rvx_pkg::F7_BASE)
                            || (w_f3 == 3'd5 && w_f7 != rvx_pkg::F7_BASE
                                && w_f7 != rvx_pkg::F7_ALT)) begin
                            r_bad <= 1'b1;
                        end else begin
                            r_wr  <= 1'b1;
                            r_val <= alu(w_f3, w_f3 == 3'd5 && w_f7 == rvx_pkg::F7_ALT,
                                         w_a, w_imm_i);
                        end
                    end
                    rvx_pkg::OPC_OP: begin
                        if (w_f7 == rvx_pkg::F7_MD) begin
                            r_wr <= 1'b1;
                        end else if (w_f7 == rvx_pkg::F7_BASE) begin
                            r_wr  <= 1'b1;
                            r_val <= alu(w_f3, 1'b0, w_a, w_b);
                        end else if (w_f7 == rvx_pkg::F7_ALT
                                     && (w_f3 == 3'd0 || w_f3 == 3'd5)) begin
                            r_wr  <= 1'b1;
                            r_val <= alu(w_f3, 1'b1, w_a, w_b);
                        end else begin
                            r_bad <= 1'b1;
                        end
                    end
                    rvx_pkg::OPC_BRANCH: begin
                        if (w_f3 == 3'd2 || w_f3 == 3'd3) begin
                            r_bad <= 1'b1;
                        end else if (w_cond) begin
                            r_taken <= 1'b1;
                            r_next  <= r_pc + w_imm_b;
                        end
                    end
                    default: r_bad <= 1'b1;
                endcase
            end
            if (r_state == S_MD && w_mdrsp.done) begin
                r_val <= w_mdrsp.result;
            end
            if (r_state == S_MEMW && w_mrsp.done) begin
                r_acc <= w_acc_n;
                r_cnt <= r_cnt + 2'd1;
                if (!r_store) begin
                    r_wr  <= 1'b1;
                    r_val <= w_ld;
                end
            end
            if (w_commit) begin
                r_pc     <= r_next;
                r_ovalid <= 1'b1;
                r_owe    <= r_wr && (w_rd != 5'd0);
                r_ord    <= (r_wr && w_rd != 5'd0) ? w_rd : 5'd0;
                r_oval   <= (r_wr && w_rd != 5'd0) ? r_val : 32'd0;
                r_otaken <= r_taken;
                r_onext  <= r_next;
                r_obad   <= r_bad;
            end else if (r_ovalid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign i_instr.ready         = (r_state == S_IDLE) && w_mrsp.ready;
    assign o_result.valid        = r_ovalid;
    assign o_result.write_enable = r_owe;
    assign o_result.dest_index   = r_ord;
    assign o_result.write_value  = r_oval;
    assign o_result.branch_taken = r_otaken;
    assign o_result.next_address = r_onext;
    assign o_result.illegal      = r_obad;

    assign prdata = (paddr == rvx_pkg::REG_START_ADDRESS) ? r_start : 32'd0;
    assign pready = 1'b1;
endmodule

>>> src/rvx_regfile.sv
// 32 x 32 register file: synchronous two-port read, one write port.
// Valid bits make unwritten entries and x0 read as zero. No dependencies.
module rvx_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [4:0]  i_ra,
    input  logic [4:0]  i_rb,
    input  logic        i_we,
    input  logic [4:0]  i_wa,
    input  logic [31:0] i_wd,
    output logic [31:0] o_a,
    output logic [31:0] o_b
);
    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_da;
    logic [31:0] r_db;
    logic        r_va;
    logic        r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_rd_en) begin
            r_da <= r_mem[i_ra];
            r_db <= r_mem[i_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wa] <= 1'b1;
            end
            if (i_rd_en) begin
                r_va <= r_vld[i_ra] && (i_ra != 5'd0);
                r_vb <= r_vld[i_rb] && (i_rb != 5'd0);
            end
        end
    end

    assign o_a = r_va ? r_da : 32'd0;
    assign o_b = r_vb ? r_db : 32'd0;
endmodule

>>> src/rvx_dmem.sv
// Byte-access data memory with address wrap and a zeroing sweep after reset.
// Depends on rvx_pkg (t_mreq, t_mrsp).
module rvx_dmem #(
    parameter int MEM_WORDS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rvx_pkg::t_mreq i_req,
    output rvx_pkg::t_mrsp o_rsp
);
    localparam int AW        = $clog2(MEM_WORDS);
    localparam int BW        = AW + 2;
    localparam int MEM_BYTES = MEM_WORDS * 4;
    localparam bit POW2      = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    localparam logic [31:0] MOD_B = 32'(MEM_BYTES);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MEM_BYTES));

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_MOD, S_SUB, S_FIX, S_ACC, S_RD} t_state;

    logic [31:0]   r_mem [MEM_WORDS];
    t_state        r_state;
    logic [AW-1:0] r_clr;
    logic [31:0]   r_num;
    logic [63:0]   r_prod;
    logic [BW-1:0] r_ba;
    logic          r_we;
    logic [7:0]    r_wbyte;
    logic [31:0]   r_rdata;
    logic          r_done;
    logic [7:0]    r_rbyte;
    logic          w_en;
    logic [AW-1:0] w_idx;
    logic [3:0]    w_be;
    logic [31:0]   w_data;

    always_comb begin
        w_en   = 1'b0;
        w_idx  = r_ba[BW-1:2];
        w_be   = 4'b0000;
        w_data = {4{r_wbyte}};
        if (r_state == S_CLR) begin
            w_en   = 1'b1;
            w_idx  = r_clr;
            w_be   = 4'b1111;
            w_data = 32'd0;
        end else if (r_state == S_ACC && r_we) begin
            w_en = 1'b1;
            w_be = 4'b0001 << r_ba[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 4; l++) begin
                if (w_be[l]) begin
                    r_mem[w_idx][l*8 +: 8] <= w_data[l*8 +: 8];
                end
            end
        end
        if (r_state == S_ACC && !r_we) begin
            r_rdata <= r_mem[r_ba[BW-1:2]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_we    <= i_req.we;
                        r_wbyte <= i_req.wbyte;
                        r_num   <= i_req.addr;
                        if (POW2) begin
                            r_ba    <= i_req.addr[BW-1:0];
                            r_state <= S_ACC;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    // quotient estimate by reciprocal, low by at most one
                    r_prod  <= r_num * RECIP;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_num   <= r_num - (r_prod[63:32] * MOD_B);
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    if (r_num >= MOD_B) begin
                        r_ba <= BW'(r_num - MOD_B);
                    end else begin
                        r_ba <= BW'(r_num);
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_we) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_rbyte <= 8'(r_rdata >> {r_ba[1:0], 3'b000});
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.ready = (r_state == S_IDLE);
    assign o_rsp.done  = r_done;
    assign o_rsp.rbyte = r_rbyte;
endmodule

>>> src/rvx_muldiv.sv
// M-extension unit: 32x32 magnitude multiply with sign fix-up, and a
// radix-2 restoring divider. Depends on rvx_pkg (t_mdreq, t_mdrsp).
module rvx_muldiv (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rvx_pkg::t_mdreq i_req,
    output rvx_pkg::t_mdrsp o_rsp
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_FIX, S_DIV, S_DEND} t_state;

    t_state      r_state;
    logic [2:0]  r_f3;
    logic [31:0] r_a;
    logic [31:0] r_ma;
    logic [31:0] r_mb;
    logic        r_neg;
    logic        r_rneg;
    logic [63:0] r_prod;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [4:0]  r_step;
    logic        r_done;
    logic [31:0] r_res;
    logic [32:0] w_trial;
    logic [63:0] w_prod;
    logic        w_sa;
    logic        w_sb;

    assign w_trial = {r_rem, r_quo[31]};
    assign w_prod  = r_neg ? (64'd0 - r_prod) : r_prod;

    always_comb begin
        w_sa = 1'b0;
        w_sb = 1'b0;
        case (i_req.f3)
            3'd1, 3'd4, 3'd6: begin
                w_sa = i_req.a[31];
                w_sb = i_req.b[31];
            end
            3'd2: w_sa = i_req.a[31];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_f3   <= i_req.f3;
                        r_a    <= i_req.a;
                        r_ma   <= w_sa ? (32'd0 - i_req.a) : i_req.a;
                        r_mb   <= w_sb ? (32'd0 - i_req.b) : i_req.b;
                        r_neg  <= w_sa ^ w_sb;
                        r_rneg <= w_sa;
                        r_step <= '0;
                        r_rem  <= '0;
                        if (i_req.f3[2]) begin
                            r_quo   <= w_sa ? (32'd0 - i_req.a) : i_req.a;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= r_ma * r_mb;
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_res   <= (r_f3 == 3'd0) ? w_prod[31:0] : w_prod[63:32];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DIV: begin
                    if (w_trial >= {1'b0, r_mb}) begin
                        r_rem <= 32'(w_trial - {1'b0, r_mb});
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[31:0];
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_state <= S_DEND;
                    end
                end
                S_DEND: begin
                    if (r_mb == 32'd0) begin
                        r_res <= r_f3[1] ? r_a : 32'hFFFF_FFFF;
                    end else if (r_f3[1]) begin
                        r_res <= r_rneg ? (32'd0 - r_rem) : r_rem;
                    end else begin
                        r_res <= r_neg ? (32'd0 - r_quo) : r_quo;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;
endmodule

>>> src/rvx_checker.sv
// Port-level assertions for the execute unit, bound to the top level.
// Depends on rv32im_execute_unit and rvx_if.
module rvx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_we,
    input logic [4:0]  i_rd,
    input logic [31:0] i_val,
    input logic        i_taken,
    input logic [31:0] i_next,
    input logic        i_bad
);
    a_reset_no_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    a_illegal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad |-> !i_we && !i_taken)
        else $error("illegal instruction changed state");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_we |-> i_rd == 5'd0 && i_val == 32'd0)
        else $error("non-writing result carries destination data");

    a_branch_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_taken |-> !i_we)
        else $error("taken branch wrote a register");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_next) && $stable(i_val))
        else $error("stalled result changed");
endmodule

bind rv32im_execute_unit rvx_checker u_rvx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_instr.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_we        (o_result.write_enable),
    .i_rd        (o_result.dest_index),
    .i_val       (o_result.write_value),
    .i_taken     (o_result.branch_taken),
    .i_next      (o_result.next_address),
    .i_bad       (o_result.illegal)
);

>>> sim/rv32im_execute_unit_tb.sv
// Testbench for rv32im_execute_unit: random and directed RV32IM instruction streams.
// Depends on rvx_pkg, rvx_if and the execute unit RTL; predicts results internally.
`timescale 1ns / 100ps

module rv32im_execute_unit_tb;
    localparam int MEM_WORDS = 4096;
    localparam logic [2:0] REG_START_ADDRESS = rvx_pkg::REG_START_ADDRESS;
    localparam logic [6:0] OPC_LOAD   = rvx_pkg::OPC_LOAD;
    localparam logic [6:0] OPC_STORE  = rvx_pkg::OPC_STORE;
    localparam logic [6:0] OPC_OPIMM  = rvx_pkg::OPC_OPIMM;
    localparam logic [6:0] OPC_OP     = rvx_pkg::OPC_OP;
    localparam logic [6:0] OPC_BRANCH = rvx_pkg::OPC_BRANCH;
    localparam logic [6:0] F7_BASE = rvx_pkg::F7_BASE;
    localparam logic [6:0] F7_ALT  = rvx_pkg::F7_ALT;
    localparam logic [6:0] F7_MD   = rvx_pkg::F7_MD;
    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  dest_index;
        logic [31:0] write_value;
        logic        branch_taken;
        logic [31:0] next_address;
        logic        illegal;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    rvx_instr_if instr_ch ();
    rvx_result_if result_ch ();

    rv32im_execute_unit #(.MEM_WORDS(MEM_WORDS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_instr(instr_ch.sink),
        .o_result(result_ch.source), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // predictor state
    logic [31:0] gpr [32];
    logic [7:0]  dmem_bytes [MEM_WORDS*4];
    logic [31:0] pc_model;
    logic        pc_loaded;
    logic [31:0] start_addr_model;

    t_outcome expected_results[$];
    int mismatches = 0;
    int idle_pct = 15;
    int hold_cycles = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("FAIL rv32im_execute_unit");
        $finish;
    end

    function automatic logic [31:0] sx12(logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] alu_calc(logic [2:0] f3, bit alt, logic [31:0] a,
                                             logic [31:0] b);
        case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic logic [31:0] muldiv_calc(logic [2:0] f3, logic [31:0] a,
                                                logic [31:0] b);
        logic signed [63:0] sp;
        logic [63:0] up;
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        case (f3)
            3'd0: return a * b;
            3'd1: begin
                sp = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                return sp[63:32];
            end
            3'd2: begin
                up = {{32{a[31]}}, a} * {32'd0, b};
                return up[63:32];
            end
            3'd3: begin
                up = {32'd0, a} * {32'd0, b};
                return up[63:32];
            end
            3'd4: begin
                if (b == 0) return '1;
                q = ma / mb;
                return (a[31] ^ b[31]) ? -q : q;
            end
            3'd5: return (b == 0) ? '1 : a / b;
            3'd6: begin
                if (b == 0) return a;
                q = ma % mb;
                return a[31] ? -q : q;
            end
            default: return (b == 0) ? a : a % b;
        endcase
    endfunction

    function automatic logic [7:0] mem_rd(logic [31:0] addr);
        return dmem_bytes[addr % (MEM_WORDS*4)];
    endfunction

    function automatic t_outcome execute_instruction(logic [31:0] ins);
        t_outcome r;
        logic [6:0] opc;
        logic [4:0] rd;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [31:0] a, b, imm, addr, pc, nxt, val;
        logic [7:0] b0, b1, b2, b3;
        bit wr, taken, bad, cond;
        opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25];
        wr = 0; taken = 0; bad = 0; cond = 0; val = 0;
        if (!pc_loaded) begin
            pc_model = start_addr_model;
            pc_loaded = 1;
        end
        pc = pc_model;
        nxt = pc + 4;
        a = gpr[ins[19:15]];
        b = gpr[ins[24:20]];
        case (opc)
            OPC_LOAD: begin
                addr = a + sx12(ins[31:20]);
                b0 = mem_rd(addr);
                b1 = mem_rd(addr + 1);
                b2 = mem_rd(addr + 2);
                b3 = mem_rd(addr + 3);
                case (f3)
                    3'd0: val = {{24{b0[7]}}, b0};
                    3'd1: val = {{16{b1[7]}}, b1, b0};
                    3'd2: val = {b3, b2, b1, b0};
                    3'd4: val = {24'd0, b0};
                    3'd5: val = {16'd0, b1, b0};
                    default: bad = 1;
                endcase
                wr = !bad;
            end
            OPC_STORE: begin
                addr = a + sx12({f7, rd});
                if (f3 > 3'd2) bad = 1;
                else begin
                    dmem_bytes[addr % (MEM_WORDS*4)] = b[7:0];
                    if (f3 >= 3'd1) dmem_bytes[(addr+1) % (MEM_WORDS*4)] = b[15:8];
                    if (f3 == 3'd2) begin
                        dmem_bytes[(addr+2) % (MEM_WORDS*4)] = b[23:16];
                        dmem_bytes[(addr+3) % (MEM_WORDS*4)] = b[31:24];
                    end
                end
            end
            OPC_OPIMM: begin
                if ((f3 == F3_SLL && f7 != F7_BASE) ||
                    (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)) bad = 1;
                else begin
                    val = alu_calc(f3, f3 == F3_SR && f7 == F7_ALT, a, sx12(ins[31:20]));
                    wr = 1;
                end
            end
            OPC_OP: begin
                if (f7 == F7_MD) val = muldiv_calc(f3, a, b);
                else if (f7 == F7_BASE) val = alu_calc(f3, 0, a, b);
                else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))
                    val = alu_calc(f3, 1, a, b);
                else bad = 1;
                wr = !bad;
            end
            OPC_BRANCH: begin
                imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                case (f3)
                    3'd0: cond = a == b;
                    3'd1: cond = a != b;
                    3'd4: cond = $signed(a) < $signed(b);
                    3'd5: cond = !($signed(a) < $signed(b));
                    3'd6: cond = a < b;
                    3'd7: cond = a >= b;
                    default: bad = 1;
                endcase
                if (cond) begin
                    taken = 1;
                    nxt = pc + imm;
                end
            end
            default: bad = 1;
        endcase
        if (wr && rd != 0) gpr[rd] = val;
        else begin
            wr = 0; rd = 0; val = 0;
        end
        pc_model = nxt;
        r.write_enable = wr; r.dest_index = rd; r.write_value = val;
        r.branch_taken = taken; r.next_address = nxt; r.illegal = bad;
        return r;
    endfunction

    // source side
    task automatic send_instruction(logic [31:0] ins, bit may_idle = 1);
        while (may_idle && $urandom_range(99) < idle_pct) begin
            instr_ch.valid <= 0;
            @(posedge i_clk);
        end
        instr_ch.valid <= 1;
        instr_ch.instruction <= ins;
        do @(posedge i_clk); while (!instr_ch.ready);
        expected_results.push_back(execute_instruction(ins));
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == REG_START_ADDRESS) start_addr_model = data;
    endtask

    task automatic drain();
        instr_ch.valid <= 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // sink side
    always @(posedge i_clk) begin
        if (!i_rst_n) result_ch.ready <= 0;
        else if (hold_cycles > 0) begin
            result_ch.ready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else result_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        t_outcome got, exp_r;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.write_enable = result_ch.write_enable;
            got.dest_index = result_ch.dest_index;
            got.write_value = result_ch.write_value;
            got.branch_taken = result_ch.branch_taken;
            got.next_address = result_ch.next_address;
            got.illegal = result_ch.illegal;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", exp_r, got);
                end
            end
        end
    end

    // instruction builders
    function automatic logic [31:0] r_type(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                           logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] i_type(logic [6:0] opc, logic [11:0] imm, logic [4:0] rs1,
                                           logic [2:0] f3, logic [4:0] rd);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] s_type(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                           logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] b_type(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                           logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [4:0] rd, rs1, rs2;
        logic [2:0] f3;
        int kind;
        rd = 5'($urandom); rs1 = 5'($urandom); rs2 = 5'($urandom); f3 = 3'($urandom);
        kind = $urandom_range(99);
        if (kind < 20) begin
            // random offsets; addresses wrap over the whole memory
            return i_type(OPC_LOAD, 12'($urandom), rs1, f3, rd);
        end else if (kind < 38) return s_type(12'($urandom), rs2, rs1, f3);
        else if (kind < 58) begin
            if (f3 == F3_SLL) return {7'd0, 5'($urandom), rs1, f3, rd, OPC_OPIMM};
            if (f3 == F3_SR)
                return {($urandom_range(1) ? F7_ALT : F7_BASE), 5'($urandom), rs1, f3, rd,
                        OPC_OPIMM};
            return i_type(OPC_OPIMM, 12'($urandom), rs1, f3, rd);
        end else if (kind < 72) return r_type(($urandom_range(1) ? F7_ALT : F7_BASE),
                                              rs2, rs1, f3, rd);
        else if (kind < 84) return r_type(F7_MD, rs2, rs1, f3, rd);
        else if (kind < 94) return b_type(13'($urandom), rs2, rs1, f3);
        return $urandom;
    endfunction

    task automatic test_directed();
        apb_write(REG_START_ADDRESS, 32'hFFFF_FFFC);
        send_instruction(i_type(OPC_OPIMM, 12'h7FF, 5'd0, F3_ADD, 5'd1));
        send_instruction(i_type(OPC_OPIMM, 12'h800, 5'd0, F3_ADD, 5'd2));
        send_instruction(i_type(OPC_OPIMM, 12'hFFF, 5'd0, F3_ADD, 5'd3));
        send_instruction({F7_BASE, 5'd31, 5'd3, F3_SLL, 5'd4, OPC_OPIMM});
        send_instruction({F7_ALT, 5'd31, 5'd4, F3_SR, 5'd5, OPC_OPIMM});
        send_instruction({F7_BASE, 5'd1, 5'd4, F3_SR, 5'd6, OPC_OPIMM});
        send_instruction(r_type(F7_MD, 5'd3, 5'd4, 3'd4, 5'd7));
        send_instruction(r_type(F7_MD, 5'd3, 5'd4, 3'd6, 5'd8));
        send_instruction(r_type(F7_MD, 5'd0, 5'd4, 3'd4, 5'd9));
        send_instruction(r_type(F7_MD, 5'd0, 5'd4, 3'd7, 5'd10));
        send_instruction(r_type(F7_MD, 5'd3, 5'd3, 3'd1, 5'd11));
        send_instruction(r_type(F7_MD, 5'd3, 5'd4, 3'd2, 5'd12));
        send_instruction(r_type(F7_MD, 5'd3, 5'd3, 3'd3, 5'd13));
        send_instruction(s_type(12'hFFF, 5'd1, 5'd0, 3'd2));
        send_instruction(i_type(OPC_LOAD, 12'hFFF, 5'd0, 3'd2, 5'd14));
        send_instruction(i_type(OPC_LOAD, 12'h001, 5'd0, 3'd1, 5'd15));
        send_instruction(i_type(OPC_LOAD, 12'h002, 5'd0, 3'd0, 5'd0));
        send_instruction(i_type(OPC_LOAD, 12'h000, 5'd0, 3'd3, 5'd16));
        send_instruction(b_type(13'h1001, 5'd0, 5'd0, 3'd0));
        send_instruction(b_type(13'h0FFE, 5'd4, 5'd3, 3'd4));
        send_instruction(b_type(13'h0010, 5'd4, 5'd3, 3'd2));
        send_instruction({F7_MD, 5'd1, 5'd1, F3_SLL, 5'd1, OPC_OPIMM});
        send_instruction(32'h0000_0037);
        send_instruction(32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_random(int count);
        int i;
        for (i = 0; i < count; i++) begin
            idle_pct = (i >= count/3 && i < count/2) ? 0 : 15;
            send_instruction(random_instruction());
        end
        drain();
    endtask

    task automatic test_backpressure();
        int i;
        hold_cycles <= 400;
        for (i = 0; i < 30; i++) send_instruction(random_instruction(), 0);
        drain();
        for (i = 0; i < 20; i++) send_instruction(random_instruction());
        drain();
    endtask

    initial begin
        int k;
        instr_ch.valid = 0;
        instr_ch.instruction = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        i_rst_n = 0;
        for (k = 0; k < 32; k++) gpr[k] = 0;
        for (k = 0; k < MEM_WORDS*4; k++) dmem_bytes[k] = 0;
        pc_model = 0; pc_loaded = 0; start_addr_model = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        // later start_address writes have no effect after the first item
        apb_write(REG_START_ADDRESS, 32'h0000_0000);
        test_random(900);
        apb_write(REG_START_ADDRESS, 32'h1234_5678);
        test_backpressure();
        test_random(1000);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS rv32im_execute_unit");
        end else begin
            $display("FAIL rv32im_execute_unit");
        end
        $finish;
    end
endmodule

>>> files.f
src/rvx_pkg.sv
src/rvx_if.sv
src/rvx_regfile.sv
src/rvx_dmem.sv
src/rvx_muldiv.sv
src/rv32im_execute_unit.sv
src/rvx_checker.sv
sim/rv32im_execute_unit_tb.sv
